/* rtl/core/dob_pkg.sv */
// Shared types, codes and saturation helper for the damped oscillator bank.
// Used by dob_coef, dob_rk4 and damped_oscillator_bank_rk4. No dependencies.
package dob_pkg;

  typedef struct packed {
    logic signed [31:0] vel;
    logic signed [31:0] pos;
  } osc_state_t;

  typedef struct packed {
    logic [31:0] damp;
    logic [31:0] stiff;
  } osc_coef_t;

  typedef enum logic [1:0] {
    STATUS_SAMPLE = 2'd0,
    STATUS_ADDED  = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic REG_RPH = 1'b0;
  localparam logic REG_DT  = 1'b1;

  localparam logic [31:0] RPH_RESET = 32'd3373259;
  localparam logic [31:0] DT_RESET  = 32'd536871;

  // Clamp a 40-bit signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      return -32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

/* rtl/core/dob_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dob_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/dob_coef.sv */
// Stiffness and damping coefficient unit for a new oscillator.
// Depends on dob_pkg.
module dob_coef import dob_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] freq_hz,
  input  logic [15:0] damping_rate,
  input  logic [31:0] radians_per_hz,
  input  logic [31:0] sample_period,
  output logic        done,
  output osc_coef_t   coef
);

  typedef enum logic [2:0] {C_IDLE, C_M1, C_M2, C_SQ, C_SUM} cstate_t;
  cstate_t cstate;

  logic [15:0] f, xi;
  logic [47:0] pf, px;
  logic [43:0] om, xd;
  logic [31:0] bb;
  logic        ovf;
  logic [59:0] sqo, sqx;

  logic [48:0] om_w, xd_w, bb_w;
  logic [33:0] asum;

  always_comb begin
    om_w = {1'b0, pf} + 49'd8;
    xd_w = {1'b0, px} + 49'd8;
    bb_w = {1'b0, px} + 49'd4;
    asum = {1'b0, 33'((61'(sqo) + 61'd134217728) >> 28)}
         + {1'b0, 33'((61'(sqx) + 61'd134217728) >> 28)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cstate)
        C_IDLE: begin
          if (start) begin
            f      <= freq_hz;
            xi     <= damping_rate;
            cstate <= C_M1;
          end
        end
        C_M1: begin
          pf     <= 48'(f) * 48'(radians_per_hz);
          px     <= 48'(xi) * 48'(sample_period);
          cstate <= C_M2;
        end
        C_M2: begin
          om     <= om_w[47:4];
          xd     <= xd_w[47:4];
          ovf    <= (om_w[48:34] != '0) || (xd_w[48:34] != '0);
          bb     <= (bb_w[48:35] != '0) ? 32'hFFFFFFFF : bb_w[34:3];
          cstate <= C_SQ;
        end
        C_SQ: begin
          sqo    <= 60'(om[29:0]) * 60'(om[29:0]);
          sqx    <= 60'(xd[29:0]) * 60'(xd[29:0]);
          cstate <= C_SUM;
        end
        C_SUM: begin
          coef.damp  <= bb;
          coef.stiff <= (ovf || asum[33:32] != 2'b00) ? 32'hFFFFFFFF : asum[31:0];
          done       <= 1'b1;
          cstate     <= C_IDLE;
        end
        default: cstate <= C_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/dob_rk4.sv */
// One RK4 step for one oscillator on a shared multiplier and a radix-4
// divide-by-six unit. Depends on dob_pkg.
module dob_rk4 import dob_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  osc_state_t st_in,
  input  osc_coef_t  cf_in,
  output logic       done,
  output osc_state_t st_out
);

  typedef enum logic [2:0] {R_IDLE, R_MA, R_MB, R_ACC, R_NXT, R_DSET, R_DIV, R_FIN} rstate_t;
  rstate_t rstate;

  logic signed [31:0] p0, w0, tp, tw, kw;
  logic [31:0]        a, b;
  logic [1:0]         stage;
  logic signed [64:0] prod;
  logic signed [36:0] pa;
  logic signed [34:0] sp, sw;
  logic [33:0]        np, nw, qp, qw;
  logic [2:0]         rp, rw;
  logic               negp, negw;
  logic [4:0]         cnt;

  logic [31:0]        mul_x;
  logic signed [31:0] mul_y;
  logic signed [64:0] prod_add;
  logic signed [36:0] prod_rnd;
  logic signed [37:0] acc_t;
  logic signed [31:0] kw_new;
  logic signed [32:0] hp, hw;
  logic signed [34:0] sp_new, sw_new;
  logic signed [34:0] absp, absw;
  logic [4:0]         vp, vw;
  logic [1:0]         dp, dw;
  logic signed [39:0] qp_s, qw_s;

  function automatic logic [1:0] div6_digit(input logic [4:0] v);
    if (v >= 5'd18) return 2'd3;
    if (v >= 5'd12) return 2'd2;
    if (v >= 5'd6)  return 2'd1;
    return 2'd0;
  endfunction

  always_comb begin
    mul_x    = (rstate == R_MA) ? a : b;
    mul_y    = (rstate == R_MA) ? tp : tw;
    prod_add = prod + 65'sd134217728;
    prod_rnd = prod_add[64:28];
    acc_t    = {pa[36], pa} + {prod_rnd[36], prod_rnd};
    kw_new   = sat32(-{{2{acc_t[37]}}, acc_t});
    hp       = ($signed({tw[31], tw}) + 33'sd1) >>> 1;
    hw       = ($signed({kw[31], kw}) + 33'sd1) >>> 1;
    sp_new   = sp + ((stage == 2'd1 || stage == 2'd2) ? 35'(tw) <<< 1 : 35'(tw));
    sw_new   = sw + ((stage == 2'd1 || stage == 2'd2) ? 35'(kw) <<< 1 : 35'(kw));
    absp     = sp[34] ? -sp : sp;
    absw     = sw[34] ? -sw : sw;
    vp       = {rp, np[33:32]};
    vw       = {rw, nw[33:32]};
    dp       = div6_digit(vp);
    dw       = div6_digit(vw);
    qp_s     = negp ? -$signed({6'd0, qp}) : $signed({6'd0, qp});
    qw_s     = negw ? -$signed({6'd0, qw}) : $signed({6'd0, qw});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rstate <= R_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (rstate)
        R_IDLE: begin
          if (start) begin
            p0     <= st_in.pos;
            w0     <= st_in.vel;
            tp     <= st_in.pos;
            tw     <= st_in.vel;
            a      <= cf_in.stiff;
            b      <= cf_in.damp;
            sp     <= '0;
            sw     <= '0;
            stage  <= 2'd0;
            rstate <= R_MA;
          end
        end
        R_MA: begin
          prod   <= $signed({1'b0, mul_x}) * mul_y;
          rstate <= R_MB;
        end
        R_MB: begin
          pa     <= prod_rnd;
          prod   <= $signed({1'b0, mul_x}) * mul_y;
          rstate <= R_ACC;
        end
        R_ACC: begin
          kw     <= kw_new;
          rstate <= R_NXT;
        end
        R_NXT: begin
          // accumulate the weighted slopes and form the next probe state
          sp <= sp_new;
          sw <= sw_new;
          if (stage == 2'd2) begin
            tp <= sat32(40'(p0) + 40'(tw));
            tw <= sat32(40'(w0) + 40'(kw));
          end else begin
            tp <= sat32(40'(p0) + 40'(hp));
            tw <= sat32(40'(w0) + 40'(hw));
          end
          stage  <= stage + 2'd1;
          rstate <= (stage == 2'd3) ? R_DSET : R_MA;
        end
        R_DSET: begin
          negp   <= sp[34];
          negw   <= sw[34];
          np     <= absp[33:0] + 34'd3;
          nw     <= absw[33:0] + 34'd3;
          rp     <= '0;
          rw     <= '0;
          qp     <= '0;
          qw     <= '0;
          cnt    <= '0;
          rstate <= R_DIV;
        end
        R_DIV: begin
          // two quotient bits per cycle
          rp  <= 3'(vp - 5'(dp) * 5'd6);
          rw  <= 3'(vw - 5'(dw) * 5'd6);
          np  <= np << 2;
          nw  <= nw << 2;
          qp  <= {qp[31:0], dp};
          qw  <= {qw[31:0], dw};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            rstate <= R_FIN;
          end
        end
        R_FIN: begin
          st_out.pos <= sat32(40'(p0) + qp_s);
          st_out.vel <= sat32(40'(w0) + qw_s);
          done       <= 1'b1;
          rstate     <= R_IDLE;
        end
        default: rstate <= R_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/damped_oscillator_bank_rk4.sv */
// Top level of the damped oscillator bank: stream ports, APB registers,
// sequencer and the state and coefficient memories. Depends on dob_pkg, dob_ram, dob_coef, dob_rk4.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: freq_hz, damping_rate, amplitude; tuser: op
// m_*       out  m_tvalid/m_tready  tdata: sample, clipped; tuser: status
// apb       in   psel/penable       radians_per_hz @0x0, sample_period @0x4
//
// One word at a time. An add runs the coefficient unit. On a tick each of the N
// active oscillators is read from memory, stepped by the RK4 unit (shared
// multiplier, then divide-by-six) and written back. Reset is synchronous; the
// memories are not cleared, only entries below the active count are ever read.
// A finished word waits in the output register while the next word is taken.
module damped_oscillator_bank_rk4 import dob_pkg::*; #(
  parameter int NUM_OSC = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [15:0] freq_hz, [31:16] damping_rate, [47:32] amplitude
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] sample, [16] clipped, zero above
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int CW = $clog2(NUM_OSC + 1);
  localparam int SW = 32 + CW;

  typedef enum logic [2:0] {ST_IDLE, ST_ADD, ST_RD, ST_LAT, ST_RUN, ST_FIN, ST_EMIT} state_t;
  state_t state;

  logic [31:0]          radians_per_hz, sample_period;
  logic [CW-1:0]        count;
  logic [IW-1:0]        idx;
  logic signed [SW-1:0] sum;
  logic signed [15:0]   amp;
  logic signed [15:0]   res_sample;
  logic                 res_clip;
  status_t              res_status;

  logic       s_acc, cfg_wr;
  logic       st_we, cf_we, rk_start, rk_done, cf_start, cf_done;
  osc_state_t st_wdata, st_rdata, rk_out;
  osc_coef_t  cf_rdata, cf_new;
  logic [IW-1:0] waddr;
  logic signed [SW:0]    sum_rnd;
  logic signed [SW-15:0] sum_q;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_DT) ? sample_period : radians_per_hz;
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // Register file; low address bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      radians_per_hz <= RPH_RESET;
      sample_period  <= DT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RPH) begin
        radians_per_hz <= pwdata;
      end else begin
        sample_period <= pwdata;
      end
    end
  end

  always_comb begin
    cf_we    = (state == ST_ADD) && cf_done;
    st_we    = cf_we || ((state == ST_RUN) && rk_done);
    waddr    = (state == ST_ADD) ? count[IW-1:0] : idx;
    // sign-extend the Q1.15 amplitude into Q2.30
    st_wdata.pos = {amp[15], amp, 15'd0};
    st_wdata.vel = '0;
    if (state != ST_ADD) begin
      st_wdata = rk_out;
    end
    rk_start = (state == ST_LAT);
    cf_start = s_acc && (s_tuser == OP_ADD) && (count < CW'(NUM_OSC));
    sum_rnd  = {sum[SW-1], sum} + (SW+1)'(16384);
    sum_q    = sum_rnd[SW:15];
  end

  dob_ram #(.WIDTH(64), .DEPTH(NUM_OSC)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (waddr),
    .wdata (st_wdata),
    .raddr (idx),
    .rdata (st_rdata)
  );

  dob_ram #(.WIDTH(64), .DEPTH(NUM_OSC)) u_coef_ram (
    .clk   (clk),
    .we    (cf_we),
    .waddr (waddr),
    .wdata (cf_new),
    .raddr (idx),
    .rdata (cf_rdata)
  );

  dob_coef u_coef (
    .clk            (clk),
    .rst            (rst),
    .start          (cf_start),
    .freq_hz        (s_tdata[15:0]),
    .damping_rate   (s_tdata[31:16]),
    .radians_per_hz (radians_per_hz),
    .sample_period  (sample_period),
    .done           (cf_done),
    .coef           (cf_new)
  );

  dob_rk4 u_rk4 (
    .clk    (clk),
    .rst    (rst),
    .start  (rk_start),
    .st_in  (st_rdata),
    .cf_in  (cf_rdata),
    .done   (rk_done),
    .st_out (rk_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            amp        <= s_tdata[47:32];
            res_sample <= '0;
            res_clip   <= 1'b0;
            idx        <= '0;
            sum        <= '0;
            if (s_tuser == OP_ADD) begin
              if (count < CW'(NUM_OSC)) begin
                state <= ST_ADD;
              end else begin
                res_status <= STATUS_FULL;
                state      <= ST_EMIT;
              end
            end else begin
              res_status <= STATUS_SAMPLE;
              state      <= (count == '0) ? ST_EMIT : ST_RD;
            end
          end
        end
        ST_ADD: begin
          if (cf_done) begin
            count      <= count + CW'(1);
            res_status <= STATUS_ADDED;
            state      <= ST_EMIT;
          end
        end
        ST_RD:  state <= ST_LAT;
        ST_LAT: state <= ST_RUN;
        ST_RUN: begin
          // write back, accumulate, advance to the next oscillator
          if (rk_done) begin
            sum <= sum + SW'(rk_out.pos);
            if (CW'(idx) + CW'(1) == count) begin
              state <= ST_FIN;
            end else begin
              idx   <= idx + IW'(1);
              state <= ST_RD;
            end
          end
        end
        ST_FIN: begin
          if (sum_q > (SW-14)'(32767)) begin
            res_sample <= 16'sh7FFF;
            res_clip   <= 1'b1;
          end else if (sum_q < -(SW-14)'(32768)) begin
            res_sample <= -16'sh8000;
            res_clip   <= 1'b1;
          end else begin
            res_sample <= sum_q[15:0];
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_clip, res_sample};
            m_tuser  <= res_status;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(NUM_OSC))
    else $error("active count above bank size");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    st_we |-> (state == ST_ADD || state == ST_RUN))
    else $error("state memory written outside add or run");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tuser == OP_ADD && count == CW'(NUM_OSC)) |=> state == ST_EMIT
      && res_status == STATUS_FULL && $stable(count))
    else $error("add into full bank not refused");

endmodule
